// ===== hw/rtl/fnmc_pkg.sv =====
// Shared constants, types and helpers for the four-neighbour mark counter.
package fnmc_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;

    // Width of a configuration register and of the configuration index.
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 8;

    // Column position, and a count that can hold the column total itself.
    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    localparam int VALUE_W = 4;
    localparam int COUNT_W = 3;

    localparam logic [VALUE_W-1:0] MARK_VALUE = 4'd9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 8'd1;

    // Input item kinds.
    localparam logic MODE_CELL  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // One entry of the two line buffers: the pending row and the row above it.
    typedef struct packed {
        logic prev;
        logic old;
    } t_line_bits;

    // Control handed from the counters to the line chain.
    typedef struct packed {
        logic             shift;
        logic [COL_W-1:0] last_col;
    } t_chain_ctrl;

    function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [COL_CNT_W-1:0] res;
        if (v == '0) begin
            res = COL_CNT_W'(1);
        end else if (32'(v) > 32'(MAX_COLUMNS)) begin
            res = COL_CNT_W'(MAX_COLUMNS);
        end else begin
            res = COL_CNT_W'(v);
        end
        return res;
    endfunction

    function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [ROW_CNT_W-1:0] res;
        if (v == '0) begin
            res = ROW_CNT_W'(1);
        end else if (32'(v) > 32'(MAX_ROWS)) begin
            res = ROW_CNT_W'(MAX_ROWS);
        end else begin
            res = ROW_CNT_W'(v);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/fnmc_if.sv =====
// Handshake channel interfaces: cell input, result output and configuration writes.
interface fnmc_in_if;
    logic valid;
    logic ready;
    logic mode;
    logic cell_req;

    modport source (output valid, output mode, output cell_req, input ready);
    modport sink   (input valid, input mode, input cell_req, output ready);
endinterface

interface fnmc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] value;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output value, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input value, input row_end, input frame_end,
                    output ready);
endinterface

interface fnmc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/four_neighbor_mark_count.sv =====
// Top level: counters, neighbour count, output register and configuration registers.
//
// Cells of a binary grid arrive in raster order, one per item, and the block
// accepts one item every clock cycle with no gaps, as long as the result
// register is free or being emptied in the same cycle. A cell's result (9
// for a marked cell, else the number of marked up, down, left and right
// neighbours inside the grid) leaves on the cycle after the cell below it is
// accepted, so first-row items give none; after the last cell of the frame,
// one flush item per column drains the last row, the final result carrying
// frame_end. The two line buffers are a chain of one cell per column through
// which every accepted item that is not dropped shifts. Writing either size
// register restarts the frame; a cell item after a complete frame, or a flush
// item before one, is taken and dropped.
module four_neighbor_mark_count
    import fnmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fnmc_in_if.sink           i_in,
    fnmc_out_if.source        o_out,
    fnmc_cfg_if.sink          i_cfg
);

    logic [CFG_W-1:0]     r_grid_width;
    logic [CFG_W-1:0]     r_grid_height;
    logic [ROW_CNT_W-1:0] r_row;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     r_flush;
    logic                 r_hold;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_row_end;
    logic                 r_out_frame_end;

    logic [COL_CNT_W-1:0] w_width;
    logic [ROW_CNT_W-1:0] w_height;
    logic                 w_in_acc;
    logic                 w_cfg_acc;
    logic                 w_is_cell;
    logic                 w_cell_ok;
    logic                 w_flush_ok;
    logic [COL_W-1:0]     w_pos;
    logic                 w_last;
    logic                 w_produce;
    logic                 w_up;
    logic                 w_down;
    logic                 w_left;
    logic                 w_right;
    logic [COUNT_W-1:0]   w_count;
    logic [VALUE_W-1:0]   w_value;
    t_line_bits           w_tap0;
    t_line_bits           w_tap1;
    t_line_bits           w_new;
    t_chain_ctrl          w_ctrl;

    assign w_width  = clamp_cols(r_grid_width);
    assign w_height = clamp_rows(r_grid_height);

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_is_cell  = (i_in.mode == MODE_CELL);
    assign w_cell_ok  = (r_row < w_height) && (COL_CNT_W'(r_col) < w_width);
    assign w_flush_ok = (r_row >= w_height) && (COL_CNT_W'(r_flush) < w_width);

    assign w_pos  = w_is_cell ? r_col : r_flush;
    assign w_last = (COL_CNT_W'(w_pos) + COL_CNT_W'(1)) == w_width;

    assign w_ctrl.shift    = w_in_acc && (w_is_cell ? w_cell_ok : w_flush_ok);
    assign w_ctrl.last_col = COL_W'(w_width - COL_CNT_W'(1));

    // The pending-row bit moves into the older row as the new cell replaces it.
    assign w_new.prev = w_is_cell && i_in.cell_req;
    assign w_new.old  = w_is_cell && w_tap0.prev;

    fnmc_line_chain u_chain (
        .i_clk (i_clk),
        .i_ctrl(w_ctrl),
        .i_new (w_new),
        .o_tap0(w_tap0),
        .o_tap1(w_tap1)
    );

    // During the flush there is no row below, and the row above exists only
    // when the grid has more than one row.
    assign w_up    = w_tap0.old && (w_is_cell ? (r_row > ROW_CNT_W'(1))
                                              : (w_height != ROW_CNT_W'(1)));
    assign w_down  = w_is_cell && i_in.cell_req;
    assign w_left  = (w_pos != '0) && r_hold;
    assign w_right = !w_last && w_tap1.prev;

    assign w_count = COUNT_W'(w_up) + COUNT_W'(w_down) + COUNT_W'(w_left)
                   + COUNT_W'(w_right);
    assign w_value = w_tap0.prev ? MARK_VALUE : VALUE_W'(w_count);

    assign w_produce = w_in_acc && (w_is_cell ? (w_cell_ok && (r_row != '0))
                                              : w_flush_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_W'(1);
            r_grid_height <= CFG_W'(1);
            r_row         <= '0;
            r_col         <= '0;
            r_flush       <= '0;
            r_hold        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_acc && (i_cfg.index == CFG_GRID_WIDTH ||
                              i_cfg.index == CFG_GRID_HEIGHT)) begin
                if (i_cfg.index == CFG_GRID_WIDTH) begin
                    r_grid_width <= i_cfg.data;
                end else begin
                    r_grid_height <= i_cfg.data;
                end
                r_row   <= '0;
                r_col   <= '0;
                r_flush <= '0;
                r_hold  <= 1'b0;
            end else if (w_ctrl.shift) begin
                r_hold <= w_tap0.prev;
                if (w_is_cell) begin
                    if (w_last) begin
                        r_col <= '0;
                        r_row <= r_row + ROW_CNT_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end else begin
                    if (w_last) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_flush <= '0;
                        r_hold  <= 1'b0;
                    end else begin
                        r_flush <= r_flush + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_out_value     <= w_value;
            r_out_row_end   <= w_last;
            r_out_frame_end <= !w_is_cell && w_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_out_value;
    assign o_out.row_end   = r_out_row_end;
    assign o_out.frame_end = r_out_frame_end;

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_frame_end |-> r_out_row_end)
        else $error("frame_end without row_end");

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_value <= VALUE_W'(4) || r_out_value == MARK_VALUE))
        else $error("result value out of range");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= w_height)
        else $error("row index beyond grid height");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        COL_CNT_W'(r_col) < w_width)
        else $error("column index beyond grid width");

    a_flush_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_produce && !w_is_cell && w_last && !w_cfg_acc |=> r_row == '0 && r_flush == '0)
        else $error("frame not restarted after last flush item");

endmodule

// ===== hw/rtl/fnmc_cell.sv =====
// One cell of the line chain: holds one column of the pending row and the row above.
module fnmc_cell
    import fnmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic       i_load,
    input  t_line_bits i_new,
    input  t_line_bits i_next,
    output t_line_bits o_data
);

    t_line_bits r_data;

    // The entry cell takes the new item; every other cell takes its neighbour's.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_load ? i_new : i_next;
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/fnmc_line_chain.sv =====
// Row of cells forming both line buffers as one variable-length shift chain.
module fnmc_line_chain
    import fnmc_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  t_line_bits  i_new,
    output t_line_bits  o_tap0,
    output t_line_bits  o_tap1
);

    t_line_bits w_cell [MAX_COLUMNS];

    // New data enters at cell (width - 1) and walks towards cell 0, so cell 0
    // always holds what entered one row length ago and cell 1 the entry after it.
    for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
        t_line_bits w_next;
        if (g == MAX_COLUMNS - 1) begin : g_tail
            assign w_next = i_new;
        end else begin : g_body
            assign w_next = w_cell[g + 1];
        end

        fnmc_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(i_ctrl.shift),
            .i_load (i_ctrl.last_col == COL_W'(g)),
            .i_new  (i_new),
            .i_next (w_next),
            .o_data (w_cell[g])
        );
    end

    assign o_tap0 = w_cell[0];

    if (MAX_COLUMNS > 1) begin : g_tap1
        assign o_tap1 = w_cell[1];
    end else begin : g_no_tap1
        assign o_tap1 = '0;
    end

endmodule
